FILE: rtl/core/hfdcc_pkg.sv
// ----------------------------------------------------------------------------
// HDLC deframer package
// Byte codes, register indexes, result codes and the byte-wide CRC16 update.
// ----------------------------------------------------------------------------
package hfdcc_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_REFL  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_XOROUT = 2'd3;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] STATUS_GOOD    = 2'd0;
	localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
	localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

	localparam logic [15:0] CRC_POLY_RST   = 16'h1021;
	localparam logic [15:0] CRC_INIT_RST   = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT_RST = 16'h0000;

	typedef logic [15:0] crc16_t;

	// Advance the CRC by one byte, MSB first or reflected (LSB first).
	function automatic crc16_t crc16_feed(input crc16_t crc_in, input logic [7:0] b,
			input crc16_t poly, input logic reflected);
		crc16_t crc;
		crc16_t rpoly;
		for (int i = 0; i < 16; i++) begin
			rpoly[i] = poly[15-i];
		end
		if (reflected) begin
			crc = crc_in ^ {8'h00, b};
			for (int i = 0; i < 8; i++) begin
				crc = crc[0] ? ((crc >> 1) ^ rpoly) : (crc >> 1);
			end
		end else begin
			crc = crc_in ^ {b, 8'h00};
			for (int i = 0; i < 8; i++) begin
				crc = crc[15] ? ((crc << 1) ^ poly) : (crc << 1);
			end
		end
		return crc;
	endfunction

endpackage

FILE: rtl/core/hdlc_frame_decoder_crc_check.sv
// ----------------------------------------------------------------------------
// HDLC frame decoder with CRC16 check
// Removes byte stuffing, reports each decoded byte and a per-frame status.
// ----------------------------------------------------------------------------
// Usage:
//   Raw line bytes enter on rx_byte under in_valid/in_stall. Each byte gives
//   at most one result on the output channel (out_valid/out_stall): a decoded
//   data byte with its frame position (kind 0) or, on an unescaped 0x7E flag
//   that closes a frame of two or more bytes, a status with the command and
//   length bytes (kind 1). Escape bytes and short-frame flags give nothing.
//   Each byte passes the input register, then the result register. One
//   byte is taken every cycle while in_stall is low; the CRC is a byte-wide
//   update done in the single logic stage between the two registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_stall rises until the result is taken; a taken result frees
//   both registers in the same cycle.
//   Reset clears the frame state and loads the CRC registers with their
//   defaults (polynomial 0x1021, initial 0xFFFF, MSB first, no final XOR).
//   Write configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module hdlc_frame_decoder_crc_check
	import hfdcc_pkg::*;
#(
	parameter int FRAME_LIMIT = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  kind,
	output logic [7:0]            data_byte,
	output logic [7:0]            byte_index,
	output logic                  overflow,
	output logic [1:0]            frame_status,
	output logic [7:0]            command,
	output logic [7:0]            payload_length,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(FRAME_LIMIT);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W:0] LIMIT_VAL = (CNT_W+1)'(FRAME_LIMIT);

	// configuration
	crc16_t crc_poly_q, crc_init_q, crc_xorout_q;
	logic   crc_refl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q   <= CRC_POLY_RST;
			crc_init_q   <= CRC_INIT_RST;
			crc_refl_q   <= 1'b0;
			crc_xorout_q <= CRC_XOROUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CRC_POLY:   crc_poly_q   <= cfg_data;
				REG_CRC_INIT:   crc_init_q   <= cfg_data;
				REG_CRC_REFL:   crc_refl_q   <= cfg_data[0];
				REG_CRC_XOROUT: crc_xorout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame state
	logic             esc_q;
	logic [CNT_W-1:0] cnt_q;
	crc16_t           crc_q;
	logic [15:0]      last_q;
	logic [7:0]       cmd_q, len_q;

	logic             esc_n;
	logic [CNT_W-1:0] cnt_n;
	crc16_t           crc_n;
	logic [15:0]      last_n;
	logic [7:0]       cmd_n, len_n;

	logic             res_valid, res_kind, res_ovf;
	logic [7:0]       res_data, res_idx, res_cmd, res_len;
	logic [1:0]       res_status;

	logic [7:0]       b;
	logic [CNT_W:0]   cnt_inc;
	logic [CMP_W-1:0] cnt_ext;
	logic             is_data;
	crc16_t           sent_crc;

	assign cnt_ext  = CMP_W'(cnt_q);
	assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
	assign sent_crc = {last_q[7:0], last_q[15:8]};

	always_comb begin
		esc_n      = esc_q;
		cnt_n      = cnt_q;
		crc_n      = crc_q;
		last_n     = last_q;
		cmd_n      = cmd_q;
		len_n      = len_q;
		res_valid  = 1'b0;
		res_kind   = KIND_DATA;
		res_data   = 8'h00;
		res_idx    = 8'h00;
		res_ovf    = 1'b0;
		res_status = STATUS_GOOD;
		res_cmd    = 8'h00;
		res_len    = 8'h00;
		b          = byte_s1;
		is_data    = 1'b0;

		if (byte_s1 == FLAG_BYTE && !esc_q) begin
			if (cnt_ext >= CMP_W'(2)) begin
				res_valid = 1'b1;
				res_kind  = KIND_STATUS;
				res_cmd   = cmd_q;
				res_len   = len_q;
				if (cnt_ext >= CMP_W'(4) && (cnt_ext - CMP_W'(4)) == CMP_W'(len_q)) begin
					res_status = ((crc_q ^ crc_xorout_q) == sent_crc) ? STATUS_GOOD
						: STATUS_CRC_ERR;
				end else begin
					res_status = STATUS_LEN_ERR;
				end
			end
			cnt_n  = '0;
			crc_n  = crc_init_q;
			last_n = 16'h0000;
		end else if (esc_q) begin
			b       = byte_s1 ^ ESC_XOR;
			esc_n   = 1'b0;
			is_data = 1'b1;
		end else if (byte_s1 == ESC_BYTE) begin
			esc_n = 1'b1;
		end else begin
			is_data = 1'b1;
		end

		if (is_data) begin
			if (cnt_ext == CMP_W'(0)) begin
				crc_n = crc_init_q;
				cmd_n = b;
			end else if (cnt_ext == CMP_W'(1)) begin
				len_n = b;
			end else begin
				crc_n = crc16_feed(crc_q, last_q[15:8], crc_poly_q, crc_refl_q);
			end
			last_n = {last_q[7:0], b};
			// wrap at the frame limit and start a new frame
			if (cnt_inc >= LIMIT_VAL) begin
				cnt_n   = '0;
				crc_n   = crc_init_q;
				last_n  = 16'h0000;
				res_ovf = 1'b1;
			end else begin
				cnt_n = cnt_inc[CNT_W-1:0];
			end
			res_valid = 1'b1;
			res_data  = b;
			res_idx   = cnt_ext[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			cnt_q  <= '0;
			crc_q  <= CRC_INIT_RST;
			last_q <= 16'h0000;
			cmd_q  <= 8'h00;
			len_q  <= 8'h00;
		end else if (valid_s1 && advance) begin
			esc_q  <= esc_n;
			cnt_q  <= cnt_n;
			crc_q  <= crc_n;
			last_q <= last_n;
			cmd_q  <= cmd_n;
			len_q  <= len_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			kind           <= res_kind;
			data_byte      <= res_data;
			byte_index     <= res_idx;
			overflow       <= res_ovf;
			frame_status   <= res_status;
			command        <= res_cmd;
			payload_length <= res_len;
		end
	end

	// checks
	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> data_byte == 8'h00 && byte_index == 8'h00
			&& !overflow)
		else $error("status result carries data fields");

	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> frame_status == STATUS_GOOD
			&& command == 8'h00 && payload_length == 8'h00)
		else $error("data result carries status fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status != 2'd3)
		else $error("undefined frame status");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} < LIMIT_VAL)
		else $error("byte count beyond frame limit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held result");

endmodule
